[hdl/apfe_pkg.sv]
// ============================================================================
// apfe_pkg: shared types and constants of the pair-force embedder
// Holds the per-point record layout, command and register codes, and the
// request/response bundles of the bit-serial root/divide unit.
// ============================================================================
package apfe_pkg;

    localparam int FRAC_BITS   = 16;   // fraction bits of positions and averages
    localparam int SCALE_FRAC  = 16;   // fraction bits of weight and decay
    localparam int DIV_WIDE    = 40;   // quotient bits of a pair-force divide
    localparam int DIV_NARROW  = 32;   // quotient bits of an update-step divide
    localparam int ROOT_STEPS  = 32;   // result bits of a square root

    // 0.00001 in Q.FRAC_BITS, rounded to nearest, placed under a square
    localparam logic [63:0] PAIR_EPS_Q =
        64'(((64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000) << FRAC_BITS;

    localparam logic [23:0] WEIGHT_RST = 24'd65536;
    localparam logic [15:0] DECAY_RST  = 16'd62259;
    localparam logic [15:0] EPS_RST    = 16'd1;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_PAIR   = 2'd1,
        CMD_UPDATE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_WEIGHT = 2'd0,
        CFG_DECAY  = 2'd1,
        CFG_EPS    = 2'd2
    } t_cfg_idx;

    // one point: position, force accumulator, running averages
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [39:0] fx;
        logic signed [39:0] fy;
        logic        [31:0] gx;
        logic        [31:0] gy;
        logic        [31:0] dx;
        logic        [31:0] dy;
    } t_rec;

    typedef enum logic [1:0] {
        OP_SQRT  = 2'd0,
        OP_DIV40 = 2'd1,
        OP_DIV32 = 2'd2
    } t_iter_op;

    typedef struct packed {
        logic        start;
        t_iter_op    op;
        logic [63:0] num;
        logic [31:0] den;
    } t_iter_req;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [39:0] q;
    } t_iter_rsp;

endpackage

[hdl/apfe_store.sv]
// ============================================================================
// apfe_store: point record memory
// One write port and one read port; read data is registered.
// ============================================================================
module apfe_store import apfe_pkg::*; #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_rec          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_rec          o_rdata
);

    t_rec r_mem [DEPTH];
    t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/apfe_iter.sv]
// ============================================================================
// apfe_iter: bit-serial square root and divide unit
// One compare/subtract per cycle; a root takes 32 steps, a divide 32 or 40.
// ============================================================================
module apfe_iter import apfe_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_iter_req i_req,
    output t_iter_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic        r_ovf;
    logic [5:0]  r_cnt;
    t_iter_op    r_op;
    logic [63:0] r_num;
    logic [31:0] r_den;
    logic [33:0] r_rem;
    logic [39:0] r_q;

    logic [35:0] opa;
    logic [35:0] opb;
    logic [36:0] dif;
    logic        ge;
    logic [33:0] n_rem;
    logic [63:0] n_num;
    logic [39:0] n_q;

    // shared compare/subtract: root trial or divisor
    always_comb begin
        if (r_op == OP_SQRT) begin
            opa   = {r_rem, r_num[63:62]};
            opb   = 36'({r_q[31:0], 2'b01});
            n_num = r_num << 2;
        end else begin
            opa   = 36'({r_rem[31:0], r_num[63]});
            opb   = 36'(r_den);
            n_num = r_num << 1;
        end
        dif   = {1'b0, opa} - {1'b0, opb};
        ge    = ~dif[36];
        n_rem = ge ? dif[33:0] : opa[33:0];
        n_q   = {r_q[38:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_op  <= i_req.op;
                r_den <= i_req.den;
                r_ovf <= 1'b0;
                r_q   <= '0;
                unique case (i_req.op)
                    OP_SQRT: begin
                        r_num  <= i_req.num;
                        r_rem  <= '0;
                        r_cnt  <= 6'(ROOT_STEPS);
                        r_busy <= 1'b1;
                    end
                    OP_DIV40: begin
                        if (i_req.den == '0) begin
                            r_done <= 1'b1;
                        end else if (32'(i_req.num[63:DIV_WIDE]) >= i_req.den) begin
                            r_ovf  <= 1'b1;
                            r_done <= 1'b1;
                        end else begin
                            r_rem  <= 34'(i_req.num[63:DIV_WIDE]);
                            r_num  <= i_req.num << (64 - DIV_WIDE);
                            r_cnt  <= 6'(DIV_WIDE);
                            r_busy <= 1'b1;
                        end
                    end
                    OP_DIV32: begin
                        if (i_req.den == '0) begin
                            r_done <= 1'b1;
                        end else if (i_req.num[63:DIV_NARROW] >= i_req.den) begin
                            r_ovf  <= 1'b1;
                            r_done <= 1'b1;
                        end else begin
                            r_rem  <= 34'(i_req.num[63:DIV_NARROW]);
                            r_num  <= i_req.num << (64 - DIV_NARROW);
                            r_cnt  <= 6'(DIV_NARROW);
                            r_busy <= 1'b1;
                        end
                    end
                    default: begin
                        r_done <= 1'b1;
                    end
                endcase
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_num <= n_num;
                r_q   <= n_q;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp = '{done: r_done, ovf: r_ovf, q: r_q};

endmodule

[hdl/adadelta_pair_force_embedder_unit.sv]
// ============================================================================
// adadelta_pair_force_embedder_unit: 2-D spring embedder with Adadelta steps
// Point store, pair-force accumulation and per-point Adadelta update.
// ============================================================================
// Each point holds a Q16.16 position, a 40-bit force accumulator per axis
// and two running averages per axis. A load transfer writes a position and
// clears the rest of that point's record. A pair transfer reads both
// points, forms the spring force rv*(D-r)/r with r = sqrt(|rv|^2 + eps),
// optionally scales it by random_weight, adds it to point a and subtracts
// it from point b. An update transfer runs one Adadelta step per axis,
// writes the point back and produces one result; its write-back waits for
// the output register to be free. A divide that overflows or has a zero
// divisor finishes early. Both use the single bit-serial root/divide unit,
// which retires one result bit per cycle (32 per root, 40 per pair divide,
// 32 per update divide) and hands back its answer from a register, and
// one shared registered 32x32 multiplier. Items are taken one at a time:
// o_in_stall is high from acceptance until the item is done. A finished
// result sits in an output register, so the next item may be taken while
// the result waits on i_out_stall. Indexes at or above NUM_POINTS and the
// unused command code are dropped. Configuration writes are taken at any
// cycle but must only be issued while the block is idle.
module adadelta_pair_force_embedder_unit import apfe_pkg::*; #(
    parameter int NUM_POINTS = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_cmd,
    input  logic [11:0]        i_index_a,
    input  logic [11:0]        i_index_b,
    input  logic [31:0]        i_target_dist,
    input  logic               i_random_pair,
    input  logic signed [31:0] i_load_x,
    input  logic signed [31:0] i_load_y,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [11:0]        o_point_index,
    output logic signed [31:0] o_new_x,
    output logic signed [31:0] o_new_y,
    output logic               o_saturated,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    localparam int AW = $clog2(NUM_POINTS);

    typedef enum logic [35:0] {
        S_IDLE = 36'd1 << 0,
        P_RDB  = 36'd1 << 1,
        P_DIF  = 36'd1 << 2,
        P_MX   = 36'd1 << 3,
        P_MY   = 36'd1 << 4,
        P_SQ   = 36'd1 << 5,
        P_SQS  = 36'd1 << 6,
        P_SQW  = 36'd1 << 7,
        P_FM   = 36'd1 << 8,
        P_FD   = 36'd1 << 9,
        P_FW   = 36'd1 << 10,
        P_RW1  = 36'd1 << 11,
        P_RW2  = 36'd1 << 12,
        P_RW3  = 36'd1 << 13,
        P_FS   = 36'd1 << 14,
        P_WA   = 36'd1 << 15,
        P_WB   = 36'd1 << 16,
        U_RD   = 36'd1 << 17,
        U_F    = 36'd1 << 18,
        U_M1   = 36'd1 << 19,
        U_M2   = 36'd1 << 20,
        U_M3   = 36'd1 << 21,
        U_M4   = 36'd1 << 22,
        U_SG   = 36'd1 << 23,
        U_SGW  = 36'd1 << 24,
        U_SD   = 36'd1 << 25,
        U_SDW  = 36'd1 << 26,
        U_DM   = 36'd1 << 27,
        U_DD   = 36'd1 << 28,
        U_DW   = 36'd1 << 29,
        U_P    = 36'd1 << 30,
        U_Q1   = 36'd1 << 31,
        U_Q2   = 36'd1 << 32,
        U_Q3   = 36'd1 << 33,
        U_Q4   = 36'd1 << 34,
        U_WR   = 36'd1 << 35
    } t_state;

    // ---- helpers -----------------------------------------------------------
    function automatic logic [31:0] mag32(logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [31:0] clip33(logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    function automatic logic [39:0] clip41(logic signed [40:0] v);
        if (v[40] != v[39]) begin
            return v[40] ? 40'h80_0000_0000 : 40'h7F_FFFF_FFFF;
        end
        return v[39:0];
    endfunction

    function automatic logic fits32(logic signed [39:0] v);
        return (&v[39:31]) | ~(|v[39:31]);
    endfunction

    // magnitude limit of a signed 40-bit value of the given sign
    function automatic logic [39:0] sat40(logic neg, logic [63:0] m);
        if (neg) begin
            return (m > 64'h80_0000_0000) ? 40'h80_0000_0000 : m[39:0];
        end
        return (m > 64'h7F_FFFF_FFFF) ? 40'h7F_FFFF_FFFF : m[39:0];
    endfunction

    // ---- registers ---------------------------------------------------------
    t_state             r_state, n_state;
    logic [11:0]        r_idx_a, n_idx_a;
    logic [11:0]        r_idx_b, n_idx_b;
    logic [31:0]        r_dist, n_dist;
    logic               r_rnd, n_rnd;
    t_rec               r_rec_a, n_rec_a;
    t_rec               r_rec_b, n_rec_b;
    logic signed [31:0] r_rx, n_rx;
    logic signed [31:0] r_ry, n_ry;
    logic [63:0]        r_acc, n_acc;
    logic [31:0]        r_root, n_root;
    logic               r_axis, n_axis;
    logic               r_fneg, n_fneg;
    logic [39:0]        r_fmag, n_fmag;
    logic signed [39:0] r_fx, n_fx;
    logic signed [39:0] r_fy, n_fy;
    logic [31:0]        r_fm, n_fm;
    logic [31:0]        r_tmp, n_tmp;
    logic [31:0]        r_gnew, n_gnew;
    logic [31:0]        r_sg, n_sg;
    logic [31:0]        r_sd, n_sd;
    logic signed [31:0] r_dv, n_dv;
    logic               r_sat, n_sat;
    logic [63:0]        r_prod;
    logic               r_ov, n_ov;
    logic [11:0]        r_o_idx, n_o_idx;
    logic signed [31:0] r_o_x, n_o_x;
    logic signed [31:0] r_o_y, n_o_y;
    logic               r_o_sat, n_o_sat;
    logic [23:0]        r_weight;
    logic [15:0]        r_decay;
    logic [15:0]        r_eps;

    // ---- datapath wires ----------------------------------------------------
    logic               in_acc;
    logic               a_ok;
    logic               b_ok;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    t_iter_req          iter_req;
    t_iter_rsp          iter_rsp;
    logic               st_we;
    logic [AW-1:0]      st_waddr;
    t_rec               st_wdata;
    logic [AW-1:0]      st_raddr;
    t_rec               st_rdata;

    logic signed [32:0] dif_x;
    logic signed [32:0] dif_y;
    logic signed [31:0] pair_rc;
    logic signed [32:0] pair_diff;
    logic [31:0]        pair_dmag;
    logic [63:0]        rw_sum;
    logic signed [39:0] f_signed;
    logic signed [39:0] cur_f;
    logic signed [31:0] cur_p;
    logic [31:0]        cur_g;
    logic [31:0]        cur_d;
    logic signed [31:0] fv32;
    logic [63:0]        sq_val;
    logic               sq_of;
    logic [31:0]        sq_clip;
    logic [63:0]        dec_sum;
    logic [31:0]        dec_new;
    logic signed [32:0] pos_sum;
    logic [31:0]        q32;
    logic               dw_over;
    logic [31:0]        dv_new;
    t_rec               wb_base;
    t_rec               wb_rec;
    t_rec               wa_rec;
    t_rec               ld_rec;
    logic               out_free;

    assign in_acc   = i_in_valid & ~o_in_stall;
    assign a_ok     = 32'(i_index_a) < 32'(NUM_POINTS);
    assign b_ok     = 32'(i_index_b) < 32'(NUM_POINTS);
    assign out_free = ~r_ov | ~i_out_stall;

    assign dif_x     = {r_rec_a.px[31], r_rec_a.px} - {st_rdata.px[31], st_rdata.px};
    assign dif_y     = {r_rec_a.py[31], r_rec_a.py} - {st_rdata.py[31], st_rdata.py};
    assign pair_rc   = r_axis ? r_ry : r_rx;
    assign pair_diff = $signed({1'b0, r_dist}) - $signed({1'b0, r_root});
    assign pair_dmag = pair_diff[32] ? 32'(-pair_diff) : pair_diff[31:0];
    assign rw_sum    = r_acc + {r_prod[31:0], 32'd0};
    assign f_signed  = r_fneg ? 40'(40'd0 - r_fmag) : r_fmag;

    assign cur_f = r_axis ? r_rec_a.fy : r_rec_a.fx;
    assign cur_p = r_axis ? r_rec_a.py : r_rec_a.px;
    assign cur_g = r_axis ? r_rec_a.gy : r_rec_a.gx;
    assign cur_d = r_axis ? r_rec_a.dy : r_rec_a.dx;
    assign fv32  = fits32(cur_f) ? cur_f[31:0]
                                 : (cur_f[39] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    assign sq_val  = r_prod >> FRAC_BITS;
    assign sq_of   = |sq_val[63:32];
    assign sq_clip = sq_of ? 32'hFFFF_FFFF : sq_val[31:0];
    assign dec_sum = r_acc + r_prod;
    assign dec_new = 32'(dec_sum >> SCALE_FRAC);
    assign pos_sum = {cur_p[31], cur_p} + {r_dv[31], r_dv};

    // step limit: a negative step may reach -2^31, a positive one 2^31-1
    assign q32     = iter_rsp.q[31:0];
    assign dw_over = r_fneg ? (iter_rsp.ovf | (q32 > 32'h8000_0000))
                            : (iter_rsp.ovf | q32[31]);
    assign dv_new  = r_fneg ? (dw_over ? 32'h8000_0000 : 32'(32'd0 - q32))
                            : (dw_over ? 32'h7FFF_FFFF : q32);

    always_comb begin
        ld_rec    = '0;
        ld_rec.px = i_load_x;
        ld_rec.py = i_load_y;

        wa_rec    = r_rec_a;
        wa_rec.fx = clip41({r_rec_a.fx[39], r_rec_a.fx} + {r_fx[39], r_fx});
        wa_rec.fy = clip41({r_rec_a.fy[39], r_rec_a.fy} + {r_fy[39], r_fy});

        // a pair naming one point twice subtracts from the freshly added value
        wb_base   = (r_idx_a == r_idx_b) ? r_rec_a : r_rec_b;
        wb_rec    = wb_base;
        wb_rec.fx = clip41({wb_base.fx[39], wb_base.fx} - {r_fx[39], r_fx});
        wb_rec.fy = clip41({wb_base.fy[39], wb_base.fy} - {r_fy[39], r_fy});
    end

    // ---- sequencer ---------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_idx_a  = r_idx_a;
        n_idx_b  = r_idx_b;
        n_dist   = r_dist;
        n_rnd    = r_rnd;
        n_rec_a  = r_rec_a;
        n_rec_b  = r_rec_b;
        n_rx     = r_rx;
        n_ry     = r_ry;
        n_acc    = r_acc;
        n_root   = r_root;
        n_axis   = r_axis;
        n_fneg   = r_fneg;
        n_fmag   = r_fmag;
        n_fx     = r_fx;
        n_fy     = r_fy;
        n_fm     = r_fm;
        n_tmp    = r_tmp;
        n_gnew   = r_gnew;
        n_sg     = r_sg;
        n_sd     = r_sd;
        n_dv     = r_dv;
        n_sat    = r_sat;
        n_ov     = r_ov & i_out_stall;
        n_o_idx  = r_o_idx;
        n_o_x    = r_o_x;
        n_o_y    = r_o_y;
        n_o_sat  = r_o_sat;
        mul_a    = '0;
        mul_b    = '0;
        iter_req = '{start: 1'b0, op: OP_SQRT, num: r_acc, den: r_root};
        st_we    = 1'b0;
        st_waddr = AW'(r_idx_a);
        st_wdata = r_rec_a;
        st_raddr = AW'(r_idx_a);

        unique case (r_state)
            S_IDLE: begin
                st_raddr = AW'(i_index_a);
                if (in_acc) begin
                    n_idx_a = i_index_a;
                    n_idx_b = i_index_b;
                    n_dist  = i_target_dist;
                    n_rnd   = i_random_pair;
                    if (a_ok) begin
                        if (i_cmd == CMD_LOAD) begin
                            st_we    = 1'b1;
                            st_waddr = AW'(i_index_a);
                            st_wdata = ld_rec;
                        end else if (i_cmd == CMD_PAIR && b_ok) begin
                            n_state = P_RDB;
                        end else if (i_cmd == CMD_UPDATE) begin
                            n_state = U_RD;
                        end
                    end
                end
            end
            // ---- pair force ----
            P_RDB: begin
                n_rec_a  = st_rdata;
                st_raddr = AW'(r_idx_b);
                n_state  = P_DIF;
            end
            P_DIF: begin
                n_rec_b = st_rdata;
                n_rx    = clip33(dif_x);
                n_ry    = clip33(dif_y);
                n_state = P_MX;
            end
            P_MX: begin
                mul_a   = mag32(r_rx);
                mul_b   = mag32(r_rx);
                n_state = P_MY;
            end
            P_MY: begin
                mul_a   = mag32(r_ry);
                mul_b   = mag32(r_ry);
                n_acc   = r_prod + PAIR_EPS_Q;
                n_state = P_SQ;
            end
            P_SQ: begin
                n_acc   = r_acc + r_prod;
                n_state = P_SQS;
            end
            P_SQS: begin
                iter_req.start = 1'b1;
                iter_req.op    = OP_SQRT;
                iter_req.num   = r_acc;
                n_state        = P_SQW;
            end
            P_SQW: begin
                if (iter_rsp.done) begin
                    n_root  = iter_rsp.q[31:0];
                    n_axis  = 1'b0;
                    n_state = P_FM;
                end
            end
            P_FM: begin
                mul_a   = mag32(pair_rc);
                mul_b   = pair_dmag;
                n_fneg  = pair_rc[31] ^ pair_diff[32];
                n_state = P_FD;
            end
            P_FD: begin
                iter_req.start = 1'b1;
                iter_req.op    = OP_DIV40;
                iter_req.num   = r_prod;
                iter_req.den   = r_root;
                n_state        = P_FW;
            end
            P_FW: begin
                if (iter_rsp.done) begin
                    n_fmag  = sat40(r_fneg, iter_rsp.ovf ? '1 : 64'(iter_rsp.q));
                    n_state = r_rnd ? P_RW1 : P_FS;
                end
            end
            P_RW1: begin
                mul_a   = r_fmag[31:0];
                mul_b   = 32'(r_weight);
                n_state = P_RW2;
            end
            P_RW2: begin
                mul_a   = 32'(r_fmag[39:32]);
                mul_b   = 32'(r_weight);
                n_acc   = r_prod;
                n_state = P_RW3;
            end
            P_RW3: begin
                n_fmag  = sat40(r_fneg, rw_sum >> SCALE_FRAC);
                n_state = P_FS;
            end
            P_FS: begin
                if (!r_axis) begin
                    n_fx    = f_signed;
                    n_axis  = 1'b1;
                    n_state = P_FM;
                end else begin
                    n_fy    = f_signed;
                    n_state = P_WA;
                end
            end
            P_WA: begin
                st_we    = 1'b1;
                st_waddr = AW'(r_idx_a);
                st_wdata = wa_rec;
                n_rec_a  = wa_rec;
                n_state  = P_WB;
            end
            P_WB: begin
                st_we    = 1'b1;
                st_waddr = AW'(r_idx_b);
                st_wdata = wb_rec;
                n_state  = S_IDLE;
            end
            // ---- Adadelta update ----
            U_RD: begin
                n_rec_a = st_rdata;
                n_axis  = 1'b0;
                n_sat   = 1'b0;
                n_state = U_F;
            end
            U_F: begin
                n_fm    = mag32(fv32);
                n_fneg  = fv32[31];
                n_sat   = r_sat | ~fits32(cur_f);
                n_state = U_M1;
            end
            U_M1: begin
                mul_a   = r_fm;
                mul_b   = r_fm;
                n_state = U_M2;
            end
            U_M2: begin
                n_tmp   = sq_clip;
                n_sat   = r_sat | sq_of;
                mul_a   = cur_g;
                mul_b   = 32'(r_decay);
                n_state = U_M3;
            end
            U_M3: begin
                mul_a   = 32'(17'h1_0000 - 17'(r_decay));
                mul_b   = r_tmp;
                n_acc   = r_prod;
                n_state = U_M4;
            end
            U_M4: begin
                n_gnew = dec_new;
                if (!r_axis) begin
                    n_rec_a.gx = dec_new;
                end else begin
                    n_rec_a.gy = dec_new;
                end
                n_state = U_SG;
            end
            U_SG: begin
                iter_req.start = 1'b1;
                iter_req.op    = OP_SQRT;
                iter_req.num   = 64'({1'b0, r_gnew} + 33'(r_eps)) << FRAC_BITS;
                n_state        = U_SGW;
            end
            U_SGW: begin
                if (iter_rsp.done) begin
                    n_sg    = iter_rsp.q[31:0];
                    n_state = U_SD;
                end
            end
            U_SD: begin
                iter_req.start = 1'b1;
                iter_req.op    = OP_SQRT;
                iter_req.num   = 64'({1'b0, cur_d} + 33'(r_eps)) << FRAC_BITS;
                n_state        = U_SDW;
            end
            U_SDW: begin
                if (iter_rsp.done) begin
                    n_sd    = iter_rsp.q[31:0];
                    n_state = U_DM;
                end
            end
            U_DM: begin
                mul_a   = r_fm;
                mul_b   = r_sd;
                n_state = U_DD;
            end
            U_DD: begin
                iter_req.start = 1'b1;
                iter_req.op    = OP_DIV32;
                iter_req.num   = r_prod;
                iter_req.den   = r_sg;
                n_state        = U_DW;
            end
            U_DW: begin
                if (iter_rsp.done) begin
                    n_dv    = dv_new;
                    n_sat   = r_sat | dw_over;
                    n_state = U_P;
                end
            end
            U_P: begin
                if (!r_axis) begin
                    n_rec_a.px = clip33(pos_sum);
                end else begin
                    n_rec_a.py = clip33(pos_sum);
                end
                n_sat   = r_sat | (pos_sum[32] ^ pos_sum[31]);
                n_fm    = mag32(r_dv);
                n_state = U_Q1;
            end
            U_Q1: begin
                mul_a   = r_fm;
                mul_b   = r_fm;
                n_state = U_Q2;
            end
            U_Q2: begin
                n_tmp   = sq_clip;
                n_sat   = r_sat | sq_of;
                mul_a   = cur_d;
                mul_b   = 32'(r_decay);
                n_state = U_Q3;
            end
            U_Q3: begin
                mul_a   = 32'(17'h1_0000 - 17'(r_decay));
                mul_b   = r_tmp;
                n_acc   = r_prod;
                n_state = U_Q4;
            end
            U_Q4: begin
                if (!r_axis) begin
                    n_rec_a.dx = dec_new;
                    n_rec_a.fx = '0;
                    n_axis     = 1'b1;
                    n_state    = U_F;
                end else begin
                    n_rec_a.dy = dec_new;
                    n_rec_a.fy = '0;
                    n_state    = U_WR;
                end
            end
            U_WR: begin
                // hold until the output register is free
                if (out_free) begin
                    st_we    = 1'b1;
                    st_waddr = AW'(r_idx_a);
                    st_wdata = r_rec_a;
                    n_ov     = 1'b1;
                    n_o_idx  = r_idx_a;
                    n_o_x    = r_rec_a.px;
                    n_o_y    = r_rec_a.py;
                    n_o_sat  = r_sat;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ov     <= 1'b0;
            r_weight <= WEIGHT_RST;
            r_decay  <= DECAY_RST;
            r_eps    <= EPS_RST;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_WEIGHT) begin
                    r_weight <= i_cfg_data;
                end else if (i_cfg_index == CFG_DECAY) begin
                    r_decay <= i_cfg_data[15:0];
                end else if (i_cfg_index == CFG_EPS) begin
                    r_eps <= i_cfg_data[15:0];
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_idx_a <= n_idx_a;
        r_idx_b <= n_idx_b;
        r_dist  <= n_dist;
        r_rnd   <= n_rnd;
        r_rec_a <= n_rec_a;
        r_rec_b <= n_rec_b;
        r_rx    <= n_rx;
        r_ry    <= n_ry;
        r_acc   <= n_acc;
        r_root  <= n_root;
        r_axis  <= n_axis;
        r_fneg  <= n_fneg;
        r_fmag  <= n_fmag;
        r_fx    <= n_fx;
        r_fy    <= n_fy;
        r_fm    <= n_fm;
        r_tmp   <= n_tmp;
        r_gnew  <= n_gnew;
        r_sg    <= n_sg;
        r_sd    <= n_sd;
        r_dv    <= n_dv;
        r_sat   <= n_sat;
        r_prod  <= mul_a * mul_b;
        r_o_idx <= n_o_idx;
        r_o_x   <= n_o_x;
        r_o_y   <= n_o_y;
        r_o_sat <= n_o_sat;
    end

    apfe_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (iter_req),
        .o_rsp   (iter_rsp)
    );

    apfe_store #(
        .DEPTH (NUM_POINTS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_ov;
    assign o_point_index = r_o_idx;
    assign o_new_x       = r_o_x;
    assign o_new_y       = r_o_y;
    assign o_saturated   = r_o_sat;

`ifndef NO_ASSERTIONS
    // the root/divide unit answers only while the sequencer waits for it
    a_iter_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iter_rsp.done |-> (r_state == P_SQW || r_state == P_FW || r_state == U_SGW ||
                           r_state == U_SDW || r_state == U_DW))
        else $error("root/divide result arrived outside a wait state");

    // a new result appears only from the write-back step of an update
    a_out_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == U_WR))
        else $error("result raised without an update write-back");

    // write-back holds while an earlier result is still stalled
    a_wr_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == U_WR && r_ov && i_out_stall) |=> (r_state == U_WR))
        else $error("update overwrote a pending result");
`endif

endmodule

[test/testbench.sv]
// ============================================================================
// testbench: pair-force embedder with Adadelta point update
// Drives load, pair, update and unused-command transfers with random gaps and
// result-side stalls. A behavioral copy of the point store predicts every
// update result, and each result is checked field by field in order.
// ============================================================================
module testbench import apfe_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         NPTS       = 4096;
    localparam int         DRAIN_WAIT = 400;   // covers the slowest item (update)

    typedef struct {
        logic [1:0]         cmd;
        logic [11:0]        a;
        logic [11:0]        b;
        logic [31:0]        tdist;
        logic               rnd;
        logic signed [31:0] lx;
        logic signed [31:0] ly;
    } t_item;

    typedef struct {
        logic [11:0] idx;
        logic [31:0] x;
        logic [31:0] y;
        logic        sat;
    } t_update_res;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_cmd = CMD_LOAD;
    logic [11:0]        i_index_a = '0;
    logic [11:0]        i_index_b = '0;
    logic [31:0]        i_target_dist = '0;
    logic               i_random_pair = 1'b0;
    logic signed [31:0] i_load_x = '0;
    logic signed [31:0] i_load_y = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [11:0]        o_point_index;
    logic signed [31:0] o_new_x;
    logic signed [31:0] o_new_y;
    logic               o_saturated;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = CFG_WEIGHT;
    logic [23:0]        i_cfg_data = '0;

    adadelta_pair_force_embedder_unit u_dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Point store mirror and register copies
    // ------------------------------------------------------------------
    longint          pos_x [NPTS];
    longint          pos_y [NPTS];
    longint          frc_x [NPTS];
    longint          frc_y [NPTS];
    longint unsigned gavg_x [NPTS];
    longint unsigned gavg_y [NPTS];
    longint unsigned davg_x [NPTS];
    longint unsigned davg_y [NPTS];
    bit              loaded [NPTS];
    int              pool [$];          // indexes that hold a loaded position

    longint unsigned weight_q = 65536;
    longint unsigned beta_q   = 62259;
    longint unsigned eps_q    = 1;

    t_update_res pending_updates [$];
    int          fail_count = 0;

    function automatic longint unsigned mag(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    // Clip a sign/magnitude pair to a signed field of the given width.
    function automatic longint sat_sm(bit neg, longint unsigned m, int bits,
                                      inout bit flag);
        longint unsigned lim;
        lim = 64'd1 << (bits - 1);
        if (neg) begin
            if (m > lim) begin flag = 1'b1; m = lim; end
            return -longint'(m);
        end
        if (m > lim - 1) begin flag = 1'b1; m = lim - 1; end
        return longint'(m);
    endfunction

    function automatic longint clip(longint v, int bits, inout bit flag);
        return sat_sm(v < 0, mag(v), bits, flag);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned square_q(longint unsigned m, inout bit flag);
        longint unsigned v;
        v = (m * m) >> FRAC_BITS;
        if (v > 64'hFFFF_FFFF) begin flag = 1'b1; v = 64'hFFFF_FFFF; end
        return v;
    endfunction

    function automatic longint unsigned decay_avg(longint unsigned avg,
                                                  longint unsigned smp);
        return (avg * beta_q + (64'd65536 - beta_q) * smp) >> 16;
    endfunction

    function automatic longint spring_force(longint rc, longint unsigned tdist,
                                            longint unsigned r, bit rnd);
        bit              junk;
        longint          diff, f;
        longint unsigned m;
        junk = 1'b0;
        diff = longint'(tdist) - longint'(r);
        m    = mag(rc) * mag(diff) / r;
        f    = sat_sm((rc < 0) != (diff < 0), m, 40, junk);
        if (rnd) f = sat_sm(f < 0, (mag(f) * weight_q) >> 16, 40, junk);
        return f;
    endfunction

    // One Adadelta step on one axis; clears the force accumulator.
    function automatic longint adadelta_axis(longint pos, inout longint frc,
                                             inout longint unsigned g,
                                             inout longint unsigned d,
                                             inout bit sat);
        longint          fv, dv;
        longint unsigned fm, sg, sd;
        fv  = clip(frc, 32, sat);
        fm  = mag(fv);
        g   = decay_avg(g, square_q(fm, sat));
        sg  = int_sqrt((eps_q + g) << FRAC_BITS);
        sd  = int_sqrt((eps_q + d) << FRAC_BITS);
        dv  = 0;
        if (sg != 0) dv = sat_sm(fv < 0, fm * sd / sg, 32, sat);
        pos = clip(pos + dv, 32, sat);
        d   = decay_avg(d, square_q(mag(dv), sat));
        frc = 0;
        return pos;
    endfunction

    function automatic void predict_item(t_item it);
        bit              junk, sat;
        longint          rx, ry, fx, fy;
        longint unsigned r;
        int              a, b;
        t_update_res     res;
        junk = 1'b0;
        sat  = 1'b0;
        a    = it.a;
        b    = it.b;
        case (it.cmd)
            CMD_LOAD: begin
                pos_x[a]  = it.lx;
                pos_y[a]  = it.ly;
                frc_x[a]  = 0;
                frc_y[a]  = 0;
                gavg_x[a] = 0;
                gavg_y[a] = 0;
                davg_x[a] = 0;
                davg_y[a] = 0;
            end
            CMD_PAIR: begin
                rx = clip(pos_x[a] - pos_x[b], 32, junk);
                ry = clip(pos_y[a] - pos_y[b], 32, junk);
                r  = int_sqrt(mag(rx) * mag(rx) + mag(ry) * mag(ry) + PAIR_EPS_Q);
                fx = 0;
                fy = 0;
                if (r != 0) begin
                    fx = spring_force(rx, it.tdist, r, it.rnd);
                    fy = spring_force(ry, it.tdist, r, it.rnd);
                end
                frc_x[a] = clip(frc_x[a] + fx, 40, junk);
                frc_y[a] = clip(frc_y[a] + fy, 40, junk);
                frc_x[b] = clip(frc_x[b] - fx, 40, junk);
                frc_y[b] = clip(frc_y[b] - fy, 40, junk);
            end
            CMD_UPDATE: begin
                pos_x[a] = adadelta_axis(pos_x[a], frc_x[a], gavg_x[a], davg_x[a], sat);
                pos_y[a] = adadelta_axis(pos_y[a], frc_y[a], gavg_y[a], davg_y[a], sat);
                res.idx  = it.a;
                res.x    = pos_x[a][31:0];
                res.y    = pos_y[a][31:0];
                res.sat  = sat;
                pending_updates.push_back(res);
            end
            default: ;   // unused command: dropped
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_update_res e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_updates.size() == 0) begin
                $error("unexpected result for point %0d", o_point_index);
                fail_count++;
            end else begin
                e = pending_updates.pop_front();
                if (o_point_index !== e.idx) begin
                    $error("point_index: expected %0d, got %0d", e.idx, o_point_index);
                    fail_count++;
                end
                if (o_new_x !== e.x) begin
                    $error("new_x: expected %h, got %h", e.x, o_new_x);
                    fail_count++;
                end
                if (o_new_y !== e.y) begin
                    $error("new_y: expected %h, got %h", e.y, o_new_y);
                    fail_count++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated: expected %0b, got %0b", e.sat, o_saturated);
                    fail_count++;
                end
            end
        end
    end

    // Result-side back-pressure: mostly short bursts, sometimes long holds,
    // sometimes short open stretches.
    initial begin
        int mode, len;
        @(posedge i_clk iff i_rst_n);
        forever begin
            mode = $urandom_range(0, 9);
            len  = (mode == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
            repeat (len) begin
                if (mode == 0)      i_out_stall <= 1'b1;
                else if (mode < 4)  i_out_stall <= 1'b0;
                else                i_out_stall <= 1'($urandom_range(0, 1));
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int idle_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 70);
    endfunction

    // Present one item, wait for its transfer and predict it. On return the
    // caller is at a clock edge and must either send again or drop valid.
    task automatic send_item(t_item it);
        int gap;
        i_cmd         <= it.cmd;
        i_index_a     <= it.a;
        i_index_b     <= it.b;
        i_target_dist <= it.tdist;
        i_random_pair <= it.rnd;
        i_load_x      <= it.lx;
        i_load_y      <= it.ly;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_item(it);
        if (it.cmd == CMD_LOAD && !loaded[it.a]) begin
            loaded[it.a] = 1'b1;
            pool.push_back(it.a);
        end
        gap = idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send(logic [1:0] cmd, int a, int b, logic [31:0] tdist, int rnd,
                        logic [31:0] lx, logic [31:0] ly);
        t_item it;
        it = '{cmd, a[11:0], b[11:0], tdist, rnd[0], lx, ly};
        send_item(it);
    endtask

    // Drop valid, let every expected result arrive, then cover the latency of
    // an item that produces none.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [23:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_WEIGHT: weight_q = val;
            CFG_DECAY:  beta_q   = val[15:0];
            default:    eps_q    = val[15:0];
        endcase
    endtask

    function automatic logic [31:0] rand_coord();
        int p;
        p = $urandom_range(0, 9);
        if (p < 2) return $urandom();
        if (p < 8) return 32'($signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000);
        return 32'($signed($urandom_range(0, 32'h7FF_FFFF)) - 32'sh400_0000);
    endfunction

    function automatic logic [31:0] rand_dist();
        int p;
        p = $urandom_range(0, 9);
        if (p < 2) return $urandom();
        if (p < 4) return '0;
        return $urandom_range(0, 32'h40_0000);
    endfunction

    function automatic int pick_loaded();
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    // Mostly loads, pairs and updates on loaded points; some unused commands.
    task automatic random_item();
        int p, a;
        p = $urandom_range(0, 99);
        if (p < 12 || pool.size() < 2) begin
            a = ($urandom_range(0, 1) || pool.size() == 0) ? $urandom_range(0, NPTS - 1)
                                                             : pick_loaded();
            send(CMD_LOAD, a, $urandom_range(0, NPTS - 1), $urandom(), $urandom_range(0, 1),
                 rand_coord(), rand_coord());
        end else if (p < 60) begin
            send(CMD_PAIR, pick_loaded(), pick_loaded(), rand_dist(), $urandom_range(0, 1),
                 $urandom(), $urandom());
        end else if (p < 95) begin
            send(CMD_UPDATE, pick_loaded(), $urandom_range(0, NPTS - 1), $urandom(),
                 $urandom_range(0, 1), $urandom(), $urandom());
        end else begin
            send(CMD_UNUSED, $urandom_range(0, NPTS - 1), $urandom_range(0, NPTS - 1),
                 $urandom(), $urandom_range(0, 1), $urandom(), $urandom());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send(CMD_LOAD, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        send(CMD_LOAD, NPTS - 1, NPTS - 1, 0, 1, 32'h8000_0000, 32'h7FFF_FFFF);
        // extreme separation and distance: saturating forces
        send(CMD_PAIR, 0, NPTS - 1, 32'hFFFF_FFFF, 0, 0, 0);
        send(CMD_PAIR, NPTS - 1, 0, 32'h0, 1, 0, 0);
        send(CMD_UPDATE, 0, 0, 0, 0, 0, 0);
        send(CMD_UPDATE, NPTS - 1, 0, 0, 0, 0, 0);
        send(CMD_LOAD, 1, 0, 0, 0, 0, 0);
        send(CMD_LOAD, 2, 0, 0, 0, 32'h0003_0000, 32'h0004_0000);
        // pair already at its target distance
        send(CMD_PAIR, 1, 2, 32'h0005_0000, 0, 0, 0);
        // same point on both sides
        send(CMD_PAIR, 1, 1, 32'h0010_0000, 1, 0, 0);
        send(CMD_PAIR, 2, 1, 32'h000A_0000, 1, 0, 0);
        send(CMD_UNUSED, 5, 7, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(CMD_UPDATE, 1, 0, 0, 0, 0, 0);
        send(CMD_UPDATE, 2, 0, 0, 0, 0, 0);
        // update with no accumulated force
        send(CMD_UPDATE, 1, 0, 0, 0, 0, 0);
        send(CMD_PAIR, 2, 1, 32'h0000_0001, 0, 0, 0);
        send(CMD_UPDATE, 2, 0, 0, 0, 0, 0);
        drain();
    endtask

    task automatic run_setting(logic [23:0] w, logic [15:0] beta, logic [15:0] eps,
                               int count);
        int p;
        write_reg(CFG_WEIGHT, w);
        write_reg(CFG_DECAY, {8'd0, beta});
        write_reg(CFG_EPS, {8'd0, eps});
        // fresh point with no force: zero grad average, zero step when eps is 0
        p = $urandom_range(0, NPTS - 1);
        send(CMD_LOAD, p, 0, 0, 0, rand_coord(), rand_coord());
        send(CMD_UPDATE, p, 0, 0, 0, 0, 0);
        repeat (count) random_item();
        drain();
    endtask

    task automatic test_config_sweep();
        run_setting(24'h0, 16'h0, 16'h0, 40);
        run_setting(24'hFF_FFFF, 16'hFFFF, 16'hFFFF, 40);
        run_setting(24'h00_8000, 16'h8000, 16'h0100, 40);
        run_setting(24'($urandom()), 16'($urandom()), 16'($urandom()), 40);
        run_setting(WEIGHT_RST, DECAY_RST, EPS_RST, 40);
    endtask

    task automatic test_random();
        repeat (850) random_item();
        // hold off until every pending result has come back
        i_in_valid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (850) random_item();
        drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_sweep();
        test_random();
        if (fail_count == 0 && pending_updates.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

[adadelta_pair_force_embedder_unit.f]
hdl/apfe_pkg.sv
hdl/apfe_store.sv
hdl/apfe_iter.sv
hdl/adadelta_pair_force_embedder_unit.sv
test/testbench.sv
